// File: rtl/smoothed_amplitude_period_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Smoothed amplitude/period tracker - assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_AMPLITUDE_PERIOD_TRACKER_CORE_MACROS_SVH
`define SMOOTHED_AMPLITUDE_PERIOD_TRACKER_CORE_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define SAPTRK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A stalled transaction keeps valid up and its payload unchanged
`define SAPTRK_HOLD(lbl, vld, rdy, sig, msg) \
    `SAPTRK_PROP(lbl, (vld) && !(rdy) |=> (vld) && $stable(sig), msg)

`endif

// File: rtl/saptrk_pkg.sv
// ----------------------------------------------------------------------------
// saptrk_pkg
// Shared codes, reset values and types of the amplitude/period tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package saptrk_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_GAIN    = 2'd0;
    localparam logic [1:0] CFG_MODE    = 2'd1;
    localparam logic [1:0] CFG_MIN_GAP = 2'd2;

    // Mode codes; the unused code behaves as filter only
    localparam logic [1:0] MODE_FILT_TRACK = 2'd0;
    localparam logic [1:0] MODE_FILT_ONLY  = 2'd1;
    localparam logic [1:0] MODE_RAW_TRACK  = 2'd2;

    // Register reset values
    localparam logic [15:0] GAIN_RST    = 16'd0;
    localparam logic [1:0]  MODE_RST    = MODE_FILT_TRACK;
    localparam logic [7:0]  MIN_GAP_RST = 8'd12;

    // Tracker result for one sample
    typedef struct packed {
        logic        turn;
        logic [14:0] amplitude;
        logic [15:0] period;
    } trk_res_t;

endpackage

`default_nettype wire

// File: rtl/saptrk_ema.sv
// ----------------------------------------------------------------------------
// saptrk_ema
// Exponential low-pass filter on a Q16.16 accumulator with a Q0.16 gain.
// ----------------------------------------------------------------------------
`default_nettype none

module saptrk_ema (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               upd,
    input  wire logic signed [15:0] sample,
    input  wire logic        [15:0] gain,
    output logic signed      [15:0] filtered
);

    logic signed [31:0] acc_reg;
    logic signed [31:0] acc_next;
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    logic signed [32:0] delta;

    // acc - floor(gain * (acc - sample * 2^16) / 2^16)
    always_comb
    begin
        diff     = {acc_reg[31], acc_reg} - {sample[15], sample, 16'd0};
        prod     = diff * $signed({1'b0, gain});
        delta    = prod[48:16];
        acc_next = acc_reg - delta[31:0];
        filtered = upd ? acc_next[31:16] : acc_reg[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (step && upd)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/saptrk_turn.sv
// ----------------------------------------------------------------------------
// saptrk_turn
// Turning point tracker: extremes, half amplitude, running period average.
// ----------------------------------------------------------------------------
`default_nettype none

module saptrk_turn (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               trk_en,
    input  wire logic signed [15:0] feed,
    input  wire logic        [7:0]  min_gap,
    output saptrk_pkg::trk_res_t    res
);

    logic signed [15:0] prev_reg;
    logic               prev_neg_reg;
    logic        [15:0] ticks_reg;
    logic        [15:0] period_reg;
    logic signed [15:0] low_reg;
    logic signed [15:0] high_reg;
    logic               rising_reg;
    logic        [14:0] amp_reg;

    logic        [15:0] ticks_next;
    logic        [15:0] period_next;
    logic signed [15:0] low_next;
    logic signed [15:0] high_next;
    logic               rising_next;
    logic        [14:0] amp_next;

    logic signed [16:0] d;
    logic               d_pos;
    logic               turn;
    logic signed [16:0] span;
    logic        [16:0] span_abs;
    logic        [16:0] per_sum;

    always_comb
    begin
        d       = {feed[15], feed} - {prev_reg[15], prev_reg};
        d_pos   = !d[16] && (d != '0);
        turn    = trk_en && ((!d[16]) == prev_neg_reg) && (ticks_reg > {8'd0, min_gap});

        low_next    = low_reg;
        high_next   = high_reg;
        rising_next = rising_reg;
        amp_next    = amp_reg;
        period_next = period_reg;
        ticks_next  = ticks_reg;

        // Latch the extreme matching the direction of the turn
        if (turn && d_pos && !rising_reg)
        begin
            low_next    = prev_reg;
            rising_next = 1'b1;
        end
        else if (turn && d[16] && rising_reg)
        begin
            high_next   = prev_reg;
            rising_next = 1'b0;
        end

        span     = {low_next[15], low_next} - {high_next[15], high_next};
        span_abs = span[16] ? 17'(-span) : 17'(span);
        per_sum  = {1'b0, ticks_reg} + {1'b0, period_reg};

        if (turn)
        begin
            amp_next = span_abs[15:1];
            if (ticks_reg != period_reg)
            begin
                period_next = per_sum[16:1];
            end
            ticks_next = '0;
        end
        else if (ticks_reg != 16'hFFFF)
        begin
            ticks_next = ticks_reg + 16'd1;
        end

        res.turn      = turn;
        res.amplitude = amp_next;
        res.period    = period_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            prev_neg_reg <= 1'b0;
            ticks_reg    <= '0;
            period_reg   <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            rising_reg   <= 1'b0;
            amp_reg      <= '0;
        end
        else if (step && trk_en)
        begin
            prev_reg     <= feed;
            prev_neg_reg <= d[16];
            ticks_reg    <= ticks_next;
            period_reg   <= period_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            rising_reg   <= rising_next;
            amp_reg      <= amp_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/smoothed_amplitude_period_tracker_core.sv
// ----------------------------------------------------------------------------
// smoothed_amplitude_period_tracker_core
// EMA filter and a turning point tracker fed by it or by the raw sample, one result per sample.
//
//  Channel  Dir  Handshake                     Content
//  s_axis   in   s_axis_tvalid/s_axis_tready   sample
//  m_axis   out  m_axis_tvalid/m_axis_tready   filtered, amplitude, period, turn
//  cfg      in   cfg_valid/cfg_ready           register index, write data
//
//  One sample per cycle sustained while m_axis_tready stays high. The filter
//  multiply and the tracker compare share the single stage between the input
//  register and the result register. Reset clears the filter, the tracker,
//  the valid flags and loads the configuration reset values; no clearing pass.
//  A stalled result holds while one more sample waits in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_amplitude_period_tracker_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] filtered, [30:16] amplitude,
                                             // [46:31] period_avg, [47] zero
    output logic             m_axis_tuser,   // [0] turn_seen
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] gain_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  min_gap_reg;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic signed [15:0] sample_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [47:0]        out_data_reg;
    logic               out_turn_reg;

    logic               step;
    logic               filt_upd;
    logic               trk_en;
    logic signed [15:0] filtered;
    logic signed [15:0] feed;
    saptrk_pkg::trk_res_t res;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= saptrk_pkg::GAIN_RST;
            mode_reg    <= saptrk_pkg::MODE_RST;
            min_gap_reg <= saptrk_pkg::MIN_GAP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                saptrk_pkg::CFG_GAIN:    gain_reg    <= cfg_data;
                saptrk_pkg::CFG_MODE:    mode_reg    <= cfg_data[1:0];
                saptrk_pkg::CFG_MIN_GAP: min_gap_reg <= cfg_data[7:0];
                default:                 ;
            endcase
        end
    end

    // Flow control
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input sample register
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sample_reg <= s_axis_tdata;
        end
    end

    // Mode decode
    assign filt_upd = (mode_reg != saptrk_pkg::MODE_RAW_TRACK);
    assign trk_en   = (mode_reg == saptrk_pkg::MODE_FILT_TRACK) ||
                      (mode_reg == saptrk_pkg::MODE_RAW_TRACK);
    assign feed     = (mode_reg == saptrk_pkg::MODE_RAW_TRACK) ? sample_reg : filtered;

    saptrk_ema u_ema (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .upd      (filt_upd),
        .sample   (sample_reg),
        .gain     (gain_reg),
        .filtered (filtered)
    );

    saptrk_turn u_turn (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .trk_en  (trk_en),
        .feed    (feed),
        .min_gap (min_gap_reg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= {1'b0, res.period, res.amplitude, filtered};
            out_turn_reg <= res.turn;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_turn_reg;

endmodule

`default_nettype wire

// File: rtl/saptrk_checker.sv
// ----------------------------------------------------------------------------
// saptrk_checker
// Port level checks of the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "smoothed_amplitude_period_tracker_core_macros.svh"

module saptrk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    logic        out_acc;
    logic        in_acc;
    logic [15:0] last_period_reg;
    logic [14:0] last_amp_reg;

    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // Last delivered period and amplitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_period_reg <= '0;
            last_amp_reg    <= '0;
        end
        else if (out_acc)
        begin
            last_period_reg <= m_axis_tdata[46:31];
            last_amp_reg    <= m_axis_tdata[30:16];
        end
    end

    `SAPTRK_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result changed under stall")
    `SAPTRK_PROP(a_out_cause, $rose(m_axis_tvalid) |-> $past(in_acc, 2), "result without sample")
    `SAPTRK_PROP(a_period_turn, out_acc && !m_axis_tuser |-> m_axis_tdata[46:31] == last_period_reg, "period moved without turn")
    `SAPTRK_PROP(a_amp_turn, out_acc && !m_axis_tuser |-> m_axis_tdata[30:16] == last_amp_reg, "amplitude moved without turn")

endmodule

bind smoothed_amplitude_period_tracker_core saptrk_checker u_saptrk_checker (.*);

`default_nettype wire
